// ----- rtl/walk_count_return_to_origin_core_assert.svh -----
// ----------------------------------------------------------------------------
// walk count core assertion macros
// concurrent checks clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef WALK_COUNT_RETURN_TO_ORIGIN_CORE_ASSERT_SVH
`define WALK_COUNT_RETURN_TO_ORIGIN_CORE_ASSERT_SVH

// same-cycle implication
`define WCRTO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("walk count core: check failed");

// next-cycle implication
`define WCRTO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("walk count core: check failed");

`endif

// ----- rtl/wcrto_pkg.sv -----
// ----------------------------------------------------------------------------
// wcrto_pkg
// shared constants and types of the walk count core
// ----------------------------------------------------------------------------
package wcrto_pkg;

  // default sizing
  localparam int MaxStepsDef     = 511;
  localparam int MaxPositionsDef = 256;

  // field widths
  localparam int StepW  = 9;
  localparam int LenW   = 20;
  localparam int CountW = 30;

  // counts are kept modulo this prime
  localparam logic [CountW-1:0] WalkModulus = 30'd1000000007;

  // controller states, one-hot
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

// ----- rtl/walk_count_return_to_origin_core.sv -----
// ----------------------------------------------------------------------------
// walk_count_return_to_origin_core
// counts walks on a clipped line that start and end at position 0, mod 1e9+7
// ----------------------------------------------------------------------------
//
// channel   | direction | transfer when     | payload
// ----------+-----------+-------------------+------------------------------
// query     | in        | start & !busy     | step_count_i, array_length_i
// result    | out       | done_o (1 cycle)  | walk_count_o
//
// a query runs S steps, S the clipped step count, over the
// n = min(array_length, S/2+1, MAX_POSITIONS) positions of the line;
// each step is one sweep over the row memory with one read per cycle
// busy stays high from the transfer until the result cycle has passed
// reset clears the controller only; the row memories hold no reset value
// the receiver cannot stall, done_o is shown for exactly one cycle

`include "walk_count_return_to_origin_core_assert.svh"

module walk_count_return_to_origin_core #(
  parameter int MAX_STEPS     = wcrto_pkg::MaxStepsDef,
  parameter int MAX_POSITIONS = wcrto_pkg::MaxPositionsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [wcrto_pkg::StepW-1:0]     step_count_i,
  input  logic [wcrto_pkg::LenW-1:0]      array_length_i,
  output logic                            done_o,
  output logic [wcrto_pkg::CountW-1:0]    walk_count_o
);
  import wcrto_pkg::*;

  // address, position count, sweep counter and step counter widths
  localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int NW = $clog2(MAX_POSITIONS + 1);
  localparam int CW = $clog2(MAX_POSITIONS + 2);
  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS + 1) : 1;
  // wide enough for the length field and the clip limits
  localparam int XW = 21;

  localparam logic [31:0] Mod1 = 32'(WalkModulus);
  localparam logic [31:0] Mod2 = 32'(WalkModulus) << 1;

  // two row memories, ping-pong: even steps write row 0, odd steps row 1
  logic [CountW-1:0] row0_mem [MAX_POSITIONS];
  logic [CountW-1:0] row1_mem [MAX_POSITIONS];
  logic [CountW-1:0] rd0_q, rd1_q;

  state_e            state_q, state_d;
  logic [SW-1:0]     steps_q, steps_d;     // clipped step count
  logic [SW-1:0]     step_q, step_d;       // step in progress
  logic [NW-1:0]     npos_q, npos_d;       // positions on the line
  logic [CW-1:0]     cyc_q, cyc_d;         // cycle within one sweep
  logic [CountW-1:0] win0_q, win0_d;       // prev_row[j-2]
  logic [CountW-1:0] win1_q, win1_d;       // prev_row[j-1]
  logic [CountW-1:0] res_q, res_d;

  logic              accept;
  logic [SW-1:0]     steps_clip;
  logic [XW-1:0]     half_w, npos_w;
  logic [CW-1:0]     npos_c;
  logic              first_step;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              arrive;
  logic [CountW-1:0] cur;
  logic [31:0]       sum;
  logic [CountW-1:0] wdata;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CW-1:0]     wr_pos;
  logic              sweep_end;

  assign accept = start && !busy;

  // query clipping: steps saturate, positions clip to steps/2+1 and depth
  always_comb begin
    if (17'(step_count_i) > 17'(MAX_STEPS)) begin
      steps_clip = SW'(MAX_STEPS);
    end else begin
      steps_clip = SW'(step_count_i);
    end
    half_w = XW'(steps_clip >> 1) + XW'(1);
    npos_w = XW'(array_length_i);
    if (npos_w > half_w) begin
      npos_w = half_w;
    end
    if (npos_w > XW'(MAX_POSITIONS)) begin
      npos_w = XW'(MAX_POSITIONS);
    end
  end

  assign npos_c     = CW'(npos_q);
  assign first_step = (step_q == '0);

  // read issue: position cyc_q of the previous row
  assign rd_en   = (state_q == StRun) && (cyc_q < npos_c);
  assign rd_addr = cyc_q[AW-1:0];

  // data for position cyc_q-1 arrives this cycle; past the end it is zero
  assign arrive = (cyc_q != '0) && (cyc_q <= npos_c);
  always_comb begin
    if (!arrive) begin
      cur = '0;
    end else if (first_step) begin
      // the starting row holds a single walk at position 0
      cur = (cyc_q == CW'(1)) ? CountW'(1) : '0;
    end else begin
      cur = step_q[0] ? rd0_q : rd1_q;
    end
  end

  // three residues below the modulus: at most two subtractions of it
  assign sum = 32'(win0_q) + 32'(win1_q) + 32'(cur);
  always_comb begin
    if (sum >= Mod2) begin
      wdata = CountW'(sum - Mod2);
    end else if (sum >= Mod1) begin
      wdata = CountW'(sum - Mod1);
    end else begin
      wdata = CountW'(sum);
    end
  end

  // next_row[cyc_q-2] is complete once its right neighbour has arrived
  assign wr_en     = (state_q == StRun) && (cyc_q >= CW'(2));
  assign wr_pos    = cyc_q - CW'(2);
  assign wr_addr   = wr_pos[AW-1:0];
  assign sweep_end = (cyc_q == npos_c + CW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en && !step_q[0]) begin
      row0_mem[wr_addr] <= wdata;
    end
    if (wr_en && step_q[0]) begin
      row1_mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rd0_q <= row0_mem[rd_addr];
      rd1_q <= row1_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    step_d  = step_q;
    npos_d  = npos_q;
    cyc_d   = cyc_q;
    win0_d  = win0_q;
    win1_d  = win1_q;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          steps_d = steps_clip;
          npos_d  = NW'(npos_w);
          step_d  = '0;
          cyc_d   = '0;
          // empty line gives no walk, zero steps gives the empty walk
          res_d   = (npos_w == '0) ? '0 : CountW'(1);
          if ((npos_w == '0) || (steps_clip == '0)) begin
            state_d = StDone;
          end else begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (cyc_q == '0) begin
          win0_d = '0;
          win1_d = '0;
        end else begin
          win0_d = win1_q;
          win1_d = cur;
        end
        if (wr_en && (wr_pos == '0)) begin
          res_d = wdata;
        end
        if (sweep_end) begin
          cyc_d  = '0;
          step_d = step_q + SW'(1);
          if (step_q + SW'(1) == steps_q) begin
            state_d = StDone;
          end
        end else begin
          cyc_d = cyc_q + CW'(1);
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      steps_q <= '0;
      step_q  <= '0;
      npos_q  <= '0;
      cyc_q   <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      step_q  <= step_d;
      npos_q  <= npos_d;
      cyc_q   <= cyc_d;
    end
  end

  // window and result are payload only
  always_ff @(posedge clk_i) begin
    win0_q <= win0_d;
    win1_q <= win1_d;
    res_q  <= res_d;
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = (state_q == StDone);
  assign walk_count_o = res_q;

  // a result is strobed for a single cycle, then the core is free
  `WCRTO_ASSERT_NXT(a_done_single, done_o, !done_o && !busy)
  // an accepted query always makes the core busy
  `WCRTO_ASSERT_NXT(a_accept_busy, accept, busy)
  // writes stay inside the clipped line
  `WCRTO_ASSERT_IMP(a_wr_in_line, wr_en, wr_pos < npos_c)
  // the reported count is a proper residue
  `WCRTO_ASSERT_IMP(a_res_reduced, done_o, walk_count_o < WalkModulus)

endmodule

// ----- test/walk_count_return_to_origin_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walk_count_return_to_origin_core_test
// drives step count / line length queries into the walk count core and checks
// every walk count against the known table value or else a bottom-up row
// recurrence kept in the bench; a short table of corner queries runs first,
// then randomised queries weighted to short walks with a handful of long ones
// ----------------------------------------------------------------------------
module walk_count_return_to_origin_core_test;

  import wcrto_pkg::*;

  // one row of the corner-case table; walks is only used when known is set
  typedef struct packed {
    logic [StepW-1:0]  steps;
    logic [LenW-1:0]   len;
    logic              known;
    logic [CountW-1:0] walks;
  } query_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [StepW-1:0]  step_count_i;
  logic [LenW-1:0]   array_length_i;
  logic              done_o;
  logic [CountW-1:0] walk_count_o;

  logic [CountW-1:0] pending_walk_counts[$];
  logic [CountW-1:0] oldest_walks;
  int                mismatch_count;
  logic              no_idle;

  // corner queries: empty line, zero steps, single position, long line clip,
  // longest walk and alternating bit patterns on both fields
  query_row_t corner_queries [18] = '{
    '{9'd0,   20'd1,       1'b1, 30'd1},
    '{9'd0,   20'd0,       1'b1, 30'd0},
    '{9'd0,   20'hFFFFF,   1'b1, 30'd1},
    '{9'd511, 20'd0,       1'b1, 30'd0},
    '{9'd1,   20'd1,       1'b1, 30'd1},
    '{9'd1,   20'hFFFFF,   1'b1, 30'd1},
    '{9'd2,   20'd2,       1'b1, 30'd2},
    '{9'd3,   20'hFFFFF,   1'b1, 30'd4},
    '{9'd4,   20'hFFFFF,   1'b1, 30'd9},
    '{9'd511, 20'd1,       1'b1, 30'd1},
    '{9'd511, 20'd2,       1'b0, 30'd0},
    '{9'd511, 20'hFFFFF,   1'b0, 30'd0},
    '{9'd256, 20'h80000,   1'b0, 30'd0},
    '{9'd170, 20'hAAAAA,   1'b0, 30'd0},
    '{9'd85,  20'h55555,   1'b0, 30'd0},
    '{9'd255, 20'd255,     1'b0, 30'd0},
    '{9'd100, 20'd50,      1'b0, 30'd0},
    '{9'd200, 20'd256,     1'b0, 30'd0}
  };

  walk_count_return_to_origin_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .step_count_i   (step_count_i),
    .array_length_i (array_length_i),
    .done_o         (done_o),
    .walk_count_o   (walk_count_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // number of returning walks, rebuilt row by row for every query
  function automatic logic [CountW-1:0] count_returning_walks(
    input logic [StepW-1:0] steps_in,
    input logic [LenW-1:0]  len_in
  );
    logic [CountW-1:0] walks_now  [MaxPositionsDef];
    logic [CountW-1:0] walks_next [MaxPositionsDef];
    longint unsigned   acc;
    int                steps;
    int                positions;
    steps = int'(steps_in);
    if (steps > MaxStepsDef) steps = MaxStepsDef;
    // positions past steps/2 can never come back in time
    positions = int'(len_in);
    if (positions > steps / 2 + 1) positions = steps / 2 + 1;
    if (positions > MaxPositionsDef) positions = MaxPositionsDef;
    if (positions == 0) return '0;
    for (int i = 0; i < positions; i++) walks_now[i] = '0;
    walks_now[0] = CountW'(1);
    for (int s = 0; s < steps; s++) begin
      for (int i = 0; i < positions; i++) begin
        acc = 64'(walks_now[i]);
        if (i > 0) acc += 64'(walks_now[i-1]);
        if (i + 1 < positions) acc += 64'(walks_now[i+1]);
        walks_next[i] = CountW'(acc % WalkModulus);
      end
      for (int i = 0; i < positions; i++) walks_now[i] = walks_next[i];
    end
    return walks_now[0];
  endfunction

  task automatic report_mismatch(input string what, input logic [CountW-1:0] got,
                                 input logic [CountW-1:0] want);
    $display("[%0t] mismatch: %s, walk_count got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // one query transfer: random hold-off unless no_idle is set, then start until busy is seen low
  task automatic send_query(input logic [StepW-1:0] steps, input logic [LenW-1:0] len,
                            input logic known, input logic [CountW-1:0] walks);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 3));
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start          <= 1'b1;
    step_count_i   <= steps;
    array_length_i <= len;
    do @(posedge clk_i); while (busy);
    // transfer taken at this edge
    pending_walk_counts.push_back(known ? walks : count_returning_walks(steps, len));
  endtask

  // start drops first so the idle core cannot take the last query twice
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_walk_counts.size() != 0) @(posedge clk_i);
  endtask

  // result side: done_o is a one-cycle strobe and cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_walk_counts.size() == 0) begin
        report_mismatch("result with no query outstanding", walk_count_o, '0);
      end else begin
        oldest_walks = pending_walk_counts.pop_front();
        if (walk_count_o !== oldest_walks)
          report_mismatch("walk count", walk_count_o, oldest_walks);
      end
    end
  end

  // stimulus
  initial begin
    logic [StepW-1:0] steps;
    logic [LenW-1:0]  len;
    int               long_left;
    rst_ni         = 1'b0;
    start          = 1'b0;
    step_count_i   = '0;
    array_length_i = '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    long_left      = 4;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // corner table first
    foreach (corner_queries[r])
      send_query(corner_queries[r].steps, corner_queries[r].len,
                 corner_queries[r].known, corner_queries[r].walks);

    // random queries, mostly short walks so the run stays short
    for (int k = 0; k < 100; k++) begin
      // alternate stretches with and without hold-off
      if (k % 16 == 0) no_idle = 1'($urandom_range(0, 1));
      // hold off until the core has nothing outstanding
      if (k == 40 || $urandom_range(0, 9) == 0) drain_results();
      if (long_left > 0 && $urandom_range(0, 24) == 0) begin
        steps = StepW'($urandom_range(128, 511));
        long_left--;
      end else begin
        steps = StepW'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 3))
        0:       len = LenW'($urandom());
        1:       len = LenW'($urandom_range(1, steps / 2 + 2));
        2:       len = LenW'($urandom_range(0, 3));
        default: len = LenW'($urandom_range(1, 300));
      endcase
      send_query(steps, len, 1'b0, '0);
    end
    @(negedge clk_i);
    start <= 1'b0;

    // let the last result arrive, then watch for stray strobes
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("walk_count_return_to_origin_core verification clean");
    end else begin
      $display("walk_count_return_to_origin_core verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("walk_count_return_to_origin_core verification failed");
    $finish;
  end

endmodule
